>>> rtl/core/crlc_pkg.sv
// shared types, constants and the crc byte step for the record line checker
package crlc_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [7:0]  SEP_RESET = 8'h7C;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last;
    logic       is_sep;
    logic       is_digit;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic [3:0] digit;
  } crlc_item_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            empty;
    logic            full;
  } crlc_qstat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crlc_front.sv
// front end: separator register, byte classification and queue push
module crlc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_line_byte,
  input  logic                in_end_of_line,
  input  crlc_pkg::crlc_qstat_t q_stat,
  output logic                push,
  output crlc_pkg::crlc_item_t  push_item
);
  import crlc_pkg::*;

  logic [7:0] sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.line_byte = in_line_byte;
    push_item.last      = in_end_of_line;
    push_item.is_sep    = (in_line_byte == sep_r);
    push_item.is_digit  = (in_line_byte >= CH_ZERO) && (in_line_byte <= CH_NINE);
    push_item.is_space  = (in_line_byte == CH_SPACE) ||
                          ((in_line_byte >= CH_TAB) && (in_line_byte <= CH_CR));
    push_item.is_plus   = (in_line_byte == CH_PLUS);
    push_item.is_minus  = (in_line_byte == CH_MINUS);
    push_item.digit     = in_line_byte[3:0];
  end

endmodule

>>> rtl/core/crlc_queue.sv
// small fifo of classified bytes between front and back
module crlc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crlc_pkg::crlc_item_t  push_item,
  input  logic                  pop,
  output crlc_pkg::crlc_item_t  head_item,
  output crlc_pkg::crlc_qstat_t q_stat
);
  import crlc_pkg::*;

  crlc_item_t      entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic [Q_CW-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = entry_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));

endmodule

>>> rtl/core/crlc_back.sv
// back end: running crc, decimal parse and the result register
module crlc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crlc_pkg::crlc_item_t  head_item,
  input  crlc_pkg::crlc_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_record_ok,
  output logic                  out_separator_found,
  output logic [31:0]           out_stored_value,
  output logic [31:0]           out_computed_crc
);
  import crlc_pkg::*;

  logic [31:0] run_crc_r, run_crc_nxt;
  logic [31:0] pay_crc_r, pay_crc_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [35:0] prod;
  logic [31:0] value;
  logic [31:0] crc_res;

  logic        out_valid_r;
  logic        ok_r;
  logic        sep_found_r;
  logic [31:0] value_r;
  logic [31:0] crc_r;

  assign pop = !q_stat.empty && (!head_item.last || !out_valid_r || out_ready);

  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {32'd0, head_item.digit};

  always_comb begin
    seen_nxt    = seen_r;
    pay_crc_nxt = pay_crc_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    neg_nxt     = neg_r;
    phase_nxt   = phase_r;
    if (head_item.is_sep) begin
      pay_crc_nxt = ~run_crc_r;
      seen_nxt    = 1'b1;
      acc_nxt     = '0;
      ovf_nxt     = 1'b0;
      neg_nxt     = 1'b0;
      phase_nxt   = PH_LEAD;
    end else if (seen_r) begin
      priority if (phase_r == PH_LEAD && head_item.is_space) begin
        phase_nxt = PH_LEAD;
      end else if (phase_r == PH_LEAD && (head_item.is_plus || head_item.is_minus)) begin
        neg_nxt   = head_item.is_minus;
        phase_nxt = PH_SIGN;
      end else if (phase_r == PH_DONE) begin
        phase_nxt = PH_DONE;
      end else if (!head_item.is_digit) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_DIGITS;
        if (!ovf_r) begin
          if (prod[35:32] != 4'd0) begin
            ovf_nxt = 1'b1;
            acc_nxt = ALL_ONES;
          end else begin
            acc_nxt = prod[31:0];
          end
        end
      end
    end
    run_crc_nxt = crc_byte(run_crc_r, head_item.line_byte);

    value   = '0;
    crc_res = '0;
    if (seen_nxt) begin
      if (ovf_nxt) begin
        value = ALL_ONES;
      end else if (neg_nxt) begin
        value = 32'd0 - acc_nxt;
      end else begin
        value = acc_nxt;
      end
      crc_res = pay_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_crc_r <= ALL_ONES;
      pay_crc_r <= '0;
      seen_r    <= 1'b0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      neg_r     <= 1'b0;
      phase_r   <= PH_LEAD;
    end else if (pop) begin
      if (head_item.last) begin
        run_crc_r <= ALL_ONES;
        pay_crc_r <= '0;
        seen_r    <= 1'b0;
        acc_r     <= '0;
        ovf_r     <= 1'b0;
        neg_r     <= 1'b0;
        phase_r   <= PH_LEAD;
      end else begin
        run_crc_r <= run_crc_nxt;
        pay_crc_r <= pay_crc_nxt;
        seen_r    <= seen_nxt;
        acc_r     <= acc_nxt;
        ovf_r     <= ovf_nxt;
        neg_r     <= neg_nxt;
        phase_r   <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      ok_r        <= seen_nxt && (value == crc_res);
      sep_found_r <= seen_nxt;
      value_r     <= value;
      crc_r       <= crc_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_ok       = ok_r;
  assign out_separator_found = sep_found_r;
  assign out_stored_value    = value_r;
  assign out_computed_crc    = crc_r;

endmodule

>>> rtl/core/crc32_record_line_checker_top.sv
// top level of the crc-32 record line checker
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_line_byte, in_end_of_line
//   out_     output     out_valid/out_ready  out_record_ok, out_separator_found,
//                                            out_stored_value, out_computed_crc
//   cfg_     input      cfg_wr_en            cfg_wr_data (separator byte)
//
// one byte per cycle sustained while results are taken; the back end does one crc byte step and one
// times-ten digit update per cycle
// a result is valid once the last byte of a line has gone through the queue and been popped into the result register
// a four-entry queue separates byte intake from the back end, so a stalled
// result only stops intake once the queue fills
// synchronous active-low reset; separator returns to '|'
module crc32_record_line_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_line_byte,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_ok,
  output logic        out_separator_found,
  output logic [31:0] out_stored_value,
  output logic [31:0] out_computed_crc
);
  import crlc_pkg::*;

  crlc_qstat_t q_stat;
  crlc_item_t  push_item;
  crlc_item_t  head_item;
  logic        push;
  logic        pop;

  crlc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_byte   (in_line_byte),
    .in_end_of_line (in_end_of_line),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  crlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  crlc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_item           (head_item),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_record_ok       (out_record_ok),
    .out_separator_found (out_separator_found),
    .out_stored_value    (out_stored_value),
    .out_computed_crc    (out_computed_crc)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.count == Q_CW'(Q_DEPTH))
    else $error("intake stalled with room in queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_ok_needs_sep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_ok |-> out_separator_found)
    else $error("record ok without separator");

  a_no_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_separator_found |-> out_stored_value == '0 && out_computed_crc == '0)
    else $error("nonzero fields without separator");

endmodule
